@@ rtl/cnl_pkg.sv @@
// ----------------------------------------------------------------------------
// cnl_pkg
// Codes, character constants and character-class helpers for the numeric
// literal lexer.
// ----------------------------------------------------------------------------
package cnl_pkg;

  localparam int CHAR_W   = 8;
  localparam int WV_W     = 2;
  localparam int ACTION_W = 3;
  localparam int RADIX_W  = 5;
  localparam int PHASE_W  = 3;
  localparam int RSEL_W   = 2;
  localparam int TAKEN_W  = 2;

  // input tdata: cur_char, next_char, next2_char, window_valid, zero fill
  localparam int S_DATA_W = 32;
  // output tdata: action, radix
  localparam int M_DATA_W = 8;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_TAKEN         = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DONE          = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ENDED         = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE          = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BAD_OCT       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TWO_POINTS    = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_NO_EXP_DIGITS = 3'd6;

  // scan phases
  localparam logic [PHASE_W-1:0] PH_MANT  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_POINT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FRACT = 3'd2;
  localparam logic [PHASE_W-1:0] PH_E     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ESIGN = 3'd4;
  localparam logic [PHASE_W-1:0] PH_EXP   = 3'd5;

  // radix selects
  localparam logic [RSEL_W-1:0] RSEL_DEC = 2'd0;
  localparam logic [RSEL_W-1:0] RSEL_OCT = 2'd1;
  localparam logic [RSEL_W-1:0] RSEL_HEX = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_8  = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_10 = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_16 = 5'd16;

  // characters
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LE    = 8'h65;
  localparam logic [CHAR_W-1:0] CH_UE    = 8'h45;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

  function automatic logic is_oct(input logic [CHAR_W-1:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic is_dec(input logic [CHAR_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic in_radix(input logic [CHAR_W-1:0] c,
                                    input logic [RSEL_W-1:0] rs);
    logic r;
    case (rs)
      RSEL_OCT: r = is_oct(c);
      RSEL_HEX: r = is_hex(c);
      default:  r = is_dec(c);
    endcase
    return r;
  endfunction

  function automatic logic [RADIX_W-1:0] radix_value(input logic [RSEL_W-1:0] rs);
    logic [RADIX_W-1:0] r;
    case (rs)
      RSEL_OCT: r = RADIX_8;
      RSEL_HEX: r = RADIX_16;
      default:  r = RADIX_10;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/c_number_literal_lexer.sv @@
// ----------------------------------------------------------------------------
// c_number_literal_lexer
// Character-at-a-time scanner for C-style numeric literals.
// ----------------------------------------------------------------------------
// Items pass through the input register, then the result register; the scan
// state updates as an item moves between them. One item per cycle while the
// output is not stalled (m_tvalid high with m_tready low holds the pipeline).
// Reset (rst, synchronous): both stages empty, scanner idle, decimal radix,
// decimal point is '.'.
module c_number_literal_lexer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic                            cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] cur_char, [15:8] next_char, [23:16] next2_char, [25:24] window_valid
  input  logic [cnl_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [2:0] action, [7:3] radix
  output logic [cnl_pkg::M_DATA_W-1:0]    m_tdata
);
  import cnl_pkg::*;

  logic                 point_is_comma;
  logic                 in_valid;
  logic [CHAR_W-1:0]    in_cur, in_n1, in_n2;
  logic [WV_W-1:0]      in_wv;
  logic                 advance;

  logic                 scanning, scanning_next;
  logic [PHASE_W-1:0]   scan_phase, scan_phase_next;
  logic [RSEL_W-1:0]    radix_sel, radix_sel_next;
  logic [TAKEN_W-1:0]   taken_count, taken_count_next;

  logic [ACTION_W-1:0]  act;
  logic [RADIX_W-1:0]   rad;

  logic [CHAR_W-1:0]    dp;
  logic                 start_ok, bad_oct, is_e, is_x, is_sign, fin;
  logic [RSEL_W-1:0]    start_rs, rs;
  logic [PHASE_W-1:0]   ph, nph;
  logic [TAKEN_W-1:0]   tc;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_is_comma <= 1'b0;
    end else if (cfg_wen) begin
      point_is_comma <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cur <= s_tdata[CHAR_W-1:0];
      in_n1  <= s_tdata[2*CHAR_W-1:CHAR_W];
      in_n2  <= s_tdata[3*CHAR_W-1:2*CHAR_W];
      in_wv  <= s_tdata[3*CHAR_W+WV_W-1:3*CHAR_W];
    end
  end

  // start-of-literal decode
  always_comb begin
    dp       = point_is_comma ? CH_COMMA : CH_DOT;
    start_ok = (in_wv != 2'd0) &&
               (is_dec(in_cur) || ((in_cur == dp) && (in_wv >= 2'd2) && is_dec(in_n1)));
    start_rs = RSEL_DEC;
    bad_oct  = 1'b0;
    if ((in_cur == CH_0) && (in_wv >= 2'd2)) begin
      if ((in_n1 == CH_LX) || (in_n1 == CH_UX)) begin
        if ((in_wv == 2'd3) && is_hex(in_n2)) start_rs = RSEL_HEX;
      end else if (is_oct(in_n1)) begin
        start_rs = RSEL_OCT;
      end else if (is_dec(in_n1)) begin
        bad_oct = 1'b1;
      end
    end
  end

  // phase machine
  always_comb begin
    is_e    = (in_cur == CH_LE) || (in_cur == CH_UE);
    is_x    = (in_cur == CH_LX) || (in_cur == CH_UX);
    is_sign = (in_cur == CH_MINUS) || (in_cur == CH_PLUS);
    rs      = scanning ? radix_sel : RSEL_DEC;
    ph      = scanning ? scan_phase : PH_MANT;
    tc      = scanning ? taken_count : 2'd0;
    nph     = ph;
    act     = ACT_TAKEN;
    fin     = 1'b0;
    if (!scanning && !start_ok) begin
      act = ACT_NONE;
      fin = 1'b1;
    end else if (!scanning && bad_oct) begin
      act = ACT_BAD_OCT;
      fin = 1'b1;
    end else begin
      if (!scanning) rs = start_rs;
      if (in_wv == 2'd0) begin
        act = ACT_ENDED;
        fin = 1'b1;
      end else if (in_radix(in_cur, rs)) begin
        if (ph == PH_POINT) nph = PH_FRACT;
        else if ((ph == PH_E) || (ph == PH_ESIGN)) nph = PH_EXP;
      end else if (in_cur == dp) begin
        fin = (ph != PH_MANT);
        if (ph == PH_MANT) nph = PH_POINT;
        else if ((ph == PH_POINT) || (ph == PH_FRACT)) act = ACT_TWO_POINTS;
        else if ((ph == PH_E) || (ph == PH_ESIGN)) act = ACT_NO_EXP_DIGITS;
        else act = ACT_ENDED;
      end else if (is_e) begin
        if ((rs == RSEL_OCT) || (rs == RSEL_HEX)) begin
          act = ACT_ENDED;
          fin = 1'b1;
        end else if ((ph == PH_MANT) || (ph == PH_POINT) || (ph == PH_FRACT)) begin
          nph = PH_E;
        end else if ((ph == PH_E) || (ph == PH_ESIGN)) begin
          act = ACT_NO_EXP_DIGITS;
          fin = 1'b1;
        end else begin
          act = ACT_ENDED;
          fin = 1'b1;
        end
      end else if (is_x) begin
        // x only right after the leading 0 of a hex literal
        if (ph == PH_MANT) begin
          if ((rs != RSEL_HEX) || (tc > 2'd1)) begin
            act = ACT_ENDED;
            fin = 1'b1;
          end
        end else if ((ph == PH_E) || (ph == PH_ESIGN)) begin
          act = ACT_NO_EXP_DIGITS;
          fin = 1'b1;
        end else begin
          act = ACT_ENDED;
          fin = 1'b1;
        end
      end else if (is_sign) begin
        if (ph == PH_E) begin
          nph = PH_ESIGN;
        end else if (ph == PH_ESIGN) begin
          act = ACT_NO_EXP_DIGITS;
          fin = 1'b1;
        end else begin
          act = ACT_ENDED;
          fin = 1'b1;
        end
      end else begin
        act = ((ph == PH_E) || (ph == PH_ESIGN)) ? ACT_NO_EXP_DIGITS : ACT_ENDED;
        fin = 1'b1;
      end

      if (!fin) begin
        if (tc < 2'd2) tc = tc + 2'd1;
        if (in_wv == 2'd1) begin
          fin = 1'b1;
          act = ((nph == PH_E) || (nph == PH_ESIGN)) ? ACT_NO_EXP_DIGITS : ACT_DONE;
        end
      end
    end
    rad = radix_value(rs);

    if (fin) begin
      scanning_next    = 1'b0;
      scan_phase_next  = PH_MANT;
      radix_sel_next   = RSEL_DEC;
      taken_count_next = 2'd0;
    end else begin
      scanning_next    = 1'b1;
      scan_phase_next  = nph;
      radix_sel_next   = rs;
      taken_count_next = tc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning    <= 1'b0;
      scan_phase  <= PH_MANT;
      radix_sel   <= RSEL_DEC;
      taken_count <= 2'd0;
    end else if (advance) begin
      scanning    <= scanning_next;
      scan_phase  <= scan_phase_next;
      radix_sel   <= radix_sel_next;
      taken_count <= taken_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {rad, act};
    end
  end

endmodule
